### design/bale_pkg.sv
`timescale 1ns / 1ps

package bale_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

### design/bale_req_if.sv
`timescale 1ns / 1ps

interface bale_req_if;
  logic                                valid;
  logic                                ready;
  logic        [bale_pkg::OP_W-1:0]    op;
  logic        [bale_pkg::IDX_W-1:0]   index;
  logic signed [bale_pkg::DATA_W-1:0]  value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

### design/bale_rsp_if.sv
`timescale 1ns / 1ps

interface bale_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [bale_pkg::STAT_W-1:0]  status;
  logic signed [bale_pkg::DATA_W-1:0]  data;
  logic        [bale_pkg::POS_W-1:0]   position;
  logic        [bale_pkg::CNT_W-1:0]   count;

  modport source (output valid, status, data, position, count, input ready);
  modport sink   (input valid, status, data, position, count, output ready);
endinterface

### design/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// one item in work at a time: a new request is taken only after the last one has finished
// (append and flagged requests walk no stored words; pop and read walk one; the rest up to DEPTH)
// the walk reads one word per cycle and writes back the words that it moves
// insert, delete, remove and find walk the store one word a cycle
// reset: count cleared to zero at once, store contents left as they are, no clearing pass

module bounded_array_list_engine #(
  parameter int unsigned DEPTH = bale_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bale_req_if.sink          req_i,
  bale_rsp_if.source        rsp_o
);
  import bale_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  bale_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  bale_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (req_i.op),
    .index_i    (req_i.index),
    .value_i    (req_i.value),
    .status_o   (rsp_o.status),
    .data_o     (rsp_o.data),
    .position_o (rsp_o.position),
    .count_o    (rsp_o.count)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

### design/bale_ram.sv
`timescale 1ns / 1ps

module bale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bale_ctrl.sv
`timescale 1ns / 1ps

module bale_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  input  bale_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output bale_pkg::cmd_t cmd_o
);
  import bale_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        // result register must be free before the next result lands
        if (sts_i.scan_done && (!out_valid_q || out_ready_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.finish | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_finish_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.scan_done)
    else $error("finish before the scan has drained");

  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_o && in_ready_o))
    else $error("finished item did not reach the output");

endmodule

### design/bale_dp.sv
`timescale 1ns / 1ps

module bale_dp #(
  parameter int unsigned DEPTH = bale_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bale_pkg::cmd_t                      cmd_i,
  output bale_pkg::sts_t                      sts_o,
  input  logic        [bale_pkg::OP_W-1:0]    op_i,
  input  logic        [bale_pkg::IDX_W-1:0]   index_i,
  input  logic signed [bale_pkg::DATA_W-1:0]  value_i,
  output logic        [bale_pkg::STAT_W-1:0]  status_o,
  output logic signed [bale_pkg::DATA_W-1:0]  data_o,
  output logic        [bale_pkg::POS_W-1:0]   position_o,
  output logic        [bale_pkg::CNT_W-1:0]   count_o
);
  import bale_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  // control state
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              pend_q, pend_d;

  // request and scan payload
  op_e               op_q;
  status_e           stat_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     widx_q;
  logic [CW-1:0]     rptr_q, rptr_d;
  logic [CW-1:0]     paddr_q;
  logic [CW-1:0]     kept_q, kept_d;
  logic              found_q, found_d;
  logic [CW-1:0]     pos_q, pos_d;

  // result register
  status_e           res_stat_q, res_stat_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;

  // request check
  op_e               op_in;
  status_e           pre_stat;
  logic [CW-1:0]     idx_w;
  logic [CW-1:0]     rem_init, rptr_init;
  logic [AW-1:0]     widx_init;
  logic              full, empty;

  // memory ports
  logic              issue;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;

  assign op_in = op_e'(op_i);
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign idx_w = CW'(index_i);

  always_comb begin
    pre_stat  = ST_OK;
    rem_init  = '0;
    rptr_init = '0;
    widx_init = AW'(count_q);
    case (op_in)
      OP_APPEND: begin
        if (full) pre_stat = ST_FULL;
      end
      OP_INSERT: begin
        if (full) begin
          pre_stat = ST_FULL;
        end else if (CMPW'(index_i) > CMPW'(count_q)) begin
          pre_stat = ST_RANGE;
        end
        rptr_init = count_q - CW'(1);
        rem_init  = count_q - idx_w;
        widx_init = AW'(index_i);
      end
      OP_POP: begin
        if (empty) pre_stat = ST_EMPTY;
        rptr_init = count_q - CW'(1);
        rem_init  = CW'(1);
      end
      OP_DELETE: begin
        if (empty) begin
          pre_stat = ST_EMPTY;
        end else if (CMPW'(index_i) >= CMPW'(count_q)) begin
          pre_stat = ST_RANGE;
        end
        rptr_init = idx_w + CW'(1);
        rem_init  = count_q - idx_w - CW'(1);
      end
      OP_REMOVE, OP_FIND: begin
        if (empty) pre_stat = ST_EMPTY;
        rem_init = count_q;
      end
      OP_READ: begin
        if (empty) begin
          pre_stat = ST_EMPTY;
        end else if (CMPW'(index_i) >= CMPW'(count_q)) begin
          pre_stat = ST_RANGE;
        end
        rptr_init = idx_w;
        rem_init  = CW'(1);
      end
      default: ;
    endcase
    // flagged requests walk nothing
    if (pre_stat != ST_OK) rem_init = '0;
  end

  // read side of the walk
  assign issue = cmd_i.step && (rem_q != '0);

  always_comb begin
    rem_d  = rem_q;
    rptr_d = rptr_q;
    pend_d = issue;
    if (cmd_i.load) begin
      rem_d  = rem_init;
      rptr_d = rptr_init;
    end else if (issue) begin
      rem_d  = rem_q - CW'(1);
      rptr_d = (op_q == OP_INSERT) ? rptr_q - CW'(1) : rptr_q + CW'(1);
    end
  end

  // write side: at most one word back per cycle, or the new word at the end of an append or insert
  always_comb begin
    we      = 1'b0;
    waddr   = widx_q;
    wdata   = rdata;
    kept_d  = kept_q;
    found_d = found_q;
    pos_d   = pos_q;
    if (cmd_i.load) begin
      kept_d  = '0;
      found_d = 1'b0;
      pos_d   = '0;
    end else if (pend_q) begin
      case (op_q)
        OP_INSERT: begin
          we    = 1'b1;
          waddr = AW'(paddr_q + CW'(1));
        end
        OP_DELETE: begin
          we    = 1'b1;
          waddr = AW'(paddr_q - CW'(1));
        end
        OP_REMOVE: begin
          if (rdata != val_q) begin
            we     = 1'b1;
            waddr  = kept_q[AW-1:0];
            kept_d = kept_q + CW'(1);
          end
        end
        OP_FIND: begin
          if (rdata == val_q && !found_q) begin
            found_d = 1'b1;
            pos_d   = paddr_q;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish && stat_q == ST_OK &&
                 (op_q == OP_APPEND || op_q == OP_INSERT)) begin
      we    = 1'b1;
      waddr = widx_q;
      wdata = val_q;
    end
  end

  // result and new count
  always_comb begin
    res_stat_d = stat_q;
    res_data_d = '0;
    res_pos_d  = '0;
    count_d    = count_q;
    if (stat_q == ST_OK) begin
      case (op_q)
        OP_APPEND, OP_INSERT: count_d = count_q + CW'(1);
        OP_POP: begin
          res_data_d = rdata;
          count_d    = count_q - CW'(1);
        end
        OP_DELETE: count_d = count_q - CW'(1);
        OP_REMOVE: begin
          count_d    = kept_q;
          res_data_d = DATA_W'(count_q - kept_q);
          if (kept_q == count_q) res_stat_d = ST_NOTFOUND;
        end
        OP_FIND: begin
          if (found_q) begin
            res_pos_d = POS_W'(pos_q);
          end else begin
            res_stat_d = ST_NOTFOUND;
          end
        end
        OP_READ: res_data_d = rdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      pend_q <= pend_d;
      if (cmd_i.finish) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q  <= rptr_d;
    paddr_q <= rptr_q;
    kept_q  <= kept_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    if (cmd_i.load) begin
      op_q   <= op_in;
      stat_q <= pre_stat;
      val_q  <= value_i;
      widx_q <= widx_init;
    end
    if (cmd_i.finish) begin
      res_stat_q <= res_stat_d;
      res_data_q <= res_data_d;
      res_pos_q  <= res_pos_d;
    end
  end

  bale_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign sts_o.scan_done = (rem_q == '0) && !pend_q;

  assign status_o   = res_stat_q;
  assign data_o     = $signed(res_data_q);
  assign position_o = res_pos_q;
  assign count_o    = CNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above capacity");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (rptr_q < count_q))
    else $error("walk reads past the held elements");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && op_q == OP_REMOVE) |-> (kept_q <= paddr_q))
    else $error("compaction overtook the read pointer");

endmodule
